// File: rtl/core/hars_pkg.sv
// Package for the health-aware round-robin selector.
// Holds list sizing constants, operation and status codes.
// No dependencies.
`default_nettype none

package hars_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int PORT_W      = 16;

    typedef enum logic {
        OP_SELECT = 1'b0,
        OP_HEALTH = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_SERVED  = 3'd0,
        ST_NONE    = 3'd1,
        ST_ADDED   = 3'd2,
        ST_PRESENT = 3'd3,
        ST_REMOVED = 3'd4,
        ST_ABSENT  = 3'd5,
        ST_FULL    = 3'd6
    } status_t;

endpackage

`default_nettype wire

// File: rtl/core/hars_req_if.sv
// Request channel of the selector: valid/ready plus one request item.
// Depends on hars_pkg.
`default_nettype none

interface hars_req_if import hars_pkg::*; ();
    logic              valid;
    logic              ready;
    op_t               operation;
    logic [PORT_W-1:0] port;
    logic              healthy;

    modport source (output valid, output operation, output port, output healthy,
                    input ready);
    modport sink   (input valid, input operation, input port, input healthy,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/hars_rsp_if.sv
// Response channel of the selector: valid/ready plus one result item.
// Depends on hars_pkg.
`default_nettype none

interface hars_rsp_if import hars_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PORT_W-1:0] chosen_port;
    status_t           status;

    modport source (output valid, output chosen_port, output status, input ready);
    modport sink   (input valid, input chosen_port, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/health_aware_round_robin_selector_unit.sv
// Health-aware round-robin selector: top level with list memory and sequencer.
// Depends on hars_pkg, hars_req_if and hars_rsp_if.
//
// The block keeps an ordered, gap-free list of healthy backend ports in a
// 32-entry single-port-write, one-read synchronous memory and hands them out
// in rotation. A select item returns none on an empty list, else the entry at
// the rotating index (wrapped to zero once it reaches the entry count), read
// through the memory read register and the result register into the output
// register. A health item walks the list one entry per cycle looking for the
// port; a passing port is appended if absent and the list is not full, a
// failing port is removed and the later entries are copied down one per
// cycle, the copy-down carrying on from the entry where the walk stopped.
// The block takes no new item until it is through with the last: one item is
// in work at a time; a finished result waits in the output register while the
// next item is accepted, and a result not yet taken holds the next one back.
// No clearing pass is needed after reset: only entries below the count are
// ever used.
`default_nettype none

module health_aware_round_robin_selector_unit import hars_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    hars_req_if.sink    req,
    hars_rsp_if.source  rsp
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SEL   = 5'b00010,
        S_SCAN  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic              healthy_reg, healthy_next;
    logic [PORT_W-1:0] port_reg, port_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  nidx_reg, nidx_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [PORT_W-1:0] res_port_reg, res_port_next;
    status_t           res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [PORT_W-1:0] out_port_reg, out_port_next;
    status_t           out_status_reg, out_status_next;

    // list memory
    logic [PORT_W-1:0] mem [MAX_ENTRIES];
    logic [PORT_W-1:0] rd_data_reg;
    logic              mem_re, mem_we;
    logic [IDX_W-1:0]  mem_ra, mem_wa;
    logic [PORT_W-1:0] mem_wd;

    logic [CNT_W-1:0]  idx_p1, idx_p2;
    logic              scan_hit, scan_last;

    assign idx_p1    = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_p2    = CNT_W'(idx_reg) + CNT_W'(2);
    assign scan_hit  = (cnt_reg != '0) && (rd_data_reg == port_reg);
    assign scan_last = (idx_p1 >= cnt_reg);

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.chosen_port = out_port_reg;
    assign rsp.status      = out_status_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        healthy_next    = healthy_reg;
        port_next       = port_reg;
        cnt_next        = cnt_reg;
        nidx_next       = nidx_reg;
        idx_next        = idx_reg;
        res_port_next   = res_port_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_port_next   = out_port_reg;
        out_status_next = out_status_reg;
        mem_re          = 1'b0;
        mem_ra          = '0;
        mem_we          = 1'b0;
        mem_wa          = '0;
        mem_wd          = '0;

        // drop the result once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    healthy_next = req.healthy;
                    port_next    = req.port;
                    if (req.operation == OP_SELECT)
                    begin
                        if (cnt_reg == '0)
                        begin
                            res_port_next   = '0;
                            res_status_next = ST_NONE;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            // wrap the rotating index before the read
                            if (nidx_reg >= cnt_reg)
                            begin
                                idx_next = '0;
                            end
                            else
                            begin
                                idx_next = nidx_reg[IDX_W-1:0];
                            end
                            mem_re     = 1'b1;
                            mem_ra     = idx_next;
                            state_next = S_SEL;
                        end
                    end
                    else
                    begin
                        // start the walk at entry zero
                        idx_next   = '0;
                        mem_re     = 1'b1;
                        mem_ra     = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SEL:
            begin
                res_port_next   = rd_data_reg;
                res_status_next = ST_SERVED;
                nidx_next       = idx_p1;
                state_next      = S_RESP;
            end

            S_SCAN:
            begin
                res_port_next = '0;
                if (scan_hit)
                begin
                    if (healthy_reg)
                    begin
                        res_status_next = ST_PRESENT;
                        state_next      = S_RESP;
                    end
                    else if (scan_last)
                    begin
                        // last entry removed: nothing to copy down
                        cnt_next        = cnt_reg - CNT_W'(1);
                        res_status_next = ST_REMOVED;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_ra     = idx_p1[IDX_W-1:0];
                        state_next = S_SHIFT;
                    end
                end
                else if (scan_last)
                begin
                    state_next = S_RESP;
                    if (!healthy_reg)
                    begin
                        res_status_next = ST_ABSENT;
                    end
                    else if (cnt_reg >= CNT_W'(MAX_ENTRIES))
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        mem_wa          = cnt_reg[IDX_W-1:0];
                        mem_wd          = port_reg;
                        cnt_next        = cnt_reg + CNT_W'(1);
                        res_status_next = ST_ADDED;
                    end
                end
                else
                begin
                    mem_re   = 1'b1;
                    mem_ra   = idx_p1[IDX_W-1:0];
                    idx_next = idx_p1[IDX_W-1:0];
                end
            end

            S_SHIFT:
            begin
                // copy entry idx+1 into idx; reads run one entry ahead
                mem_we = 1'b1;
                mem_wa = idx_reg;
                mem_wd = rd_data_reg;
                if (idx_p2 < cnt_reg)
                begin
                    mem_re   = 1'b1;
                    mem_ra   = idx_p2[IDX_W-1:0];
                    idx_next = idx_p1[IDX_W-1:0];
                end
                else
                begin
                    cnt_next        = cnt_reg - CNT_W'(1);
                    res_status_next = ST_REMOVED;
                    state_next      = S_RESP;
                end
            end

            S_RESP:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_port_next   = res_port_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            nidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            nidx_reg      <= nidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        healthy_reg    <= healthy_next;
        port_reg       <= port_next;
        idx_reg        <= idx_next;
        res_port_reg   <= res_port_next;
        res_status_reg <= res_status_next;
        out_port_reg   <= out_port_next;
        out_status_reg <= out_status_next;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above list size");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT |-> idx_p1 < cnt_reg)
        else $error("copy-down past the last entry");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg != S_IDLE)
        else $error("accepted item did not start work");

    a_port_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_SERVED |-> out_port_reg == '0)
        else $error("nonzero port on a result that is not a served select");

    a_served_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEL |-> cnt_reg != '0)
        else $error("select read on an empty list");
`endif

endmodule

`default_nettype wire

// File: sim/health_aware_round_robin_selector_unit_tb.sv
// Testbench for health_aware_round_robin_selector_unit: directed and random items,
// checked against a built-in predictor of the rotating healthy-port list.
// Depends on hars_pkg, hars_req_if, hars_rsp_if and the top level of the block.
`default_nettype none

module health_aware_round_robin_selector_unit_tb;
    import hars_pkg::*;

    // Cycles with no item accepted on either channel before the run is abandoned.
    // The slowest item and stalls on both sides stay far below this limit.
    localparam int STALL_LIMIT = 3000;
    // Quiet cycles after the last result, to catch a stray extra result.
    localparam int TAIL_CYCLES = 80;
    localparam int POOL_N      = 48;

    typedef struct packed {
        logic [PORT_W-1:0] chosen_port;
        status_t           status;
    } selection_t;

    // Predictor of the list, its count and the rotating index; holds the
    // results still owed by the block, oldest first.
    class rotation_predictor;
        logic [PORT_W-1:0] roster [MAX_ENTRIES];
        int unsigned       listed;
        int unsigned       turn;
        selection_t        awaited [$];
        int                errors;

        function new();
            foreach (roster[i])
                roster[i] = '0;
            listed = 0;
            turn   = 0;
            errors = 0;
        endfunction

        // Apply one accepted request item to the predicted state and queue its result.
        function void note_request(op_t op, logic [PORT_W-1:0] p, logic ok);
            selection_t  r;
            int unsigned slot;
            r.chosen_port = '0;
            if (op == OP_SELECT)
            begin
                if (listed == 0)
                begin
                    r.status = ST_NONE;
                end
                else
                begin
                    // Wrap before the read, then advance.
                    if (turn >= listed)
                        turn = 0;
                    r.chosen_port = roster[turn];
                    turn++;
                    r.status = ST_SERVED;
                end
            end
            else
            begin
                slot = listed;
                for (int i = listed - 1; i >= 0; i--)
                    if (roster[i] == p)
                        slot = i;
                if (ok)
                begin
                    if (slot < listed)
                        r.status = ST_PRESENT;
                    else if (listed >= MAX_ENTRIES)
                        r.status = ST_FULL;
                    else
                    begin
                        roster[listed] = p;
                        listed++;
                        r.status = ST_ADDED;
                    end
                end
                else if (slot >= listed)
                begin
                    r.status = ST_ABSENT;
                end
                else
                begin
                    // Close the gap, keep order, clear the vacated tail slot.
                    for (int unsigned i = slot; i + 1 < listed; i++)
                        roster[i] = roster[i + 1];
                    listed--;
                    roster[listed] = '0;
                    r.status = ST_REMOVED;
                end
            end
            awaited.push_back(r);
        endfunction

        function void check_result(logic [PORT_W-1:0] chosen_port, status_t status);
            selection_t e;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: chosen_port %0h status %0d", chosen_port, status);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (chosen_port !== e.chosen_port)
            begin
                $error("chosen_port: expected %0h, got %0h", e.chosen_port, chosen_port);
                errors++;
            end
            if (status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, status);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    hars_req_if req_ch ();
    hars_rsp_if rsp_ch ();

    health_aware_round_robin_selector_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    rotation_predictor predictor = new();

    // Idle chances in percent per cycle, changed per phase by the main sequence.
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    logic [PORT_W-1:0] port_pool [POOL_N];

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Drive one request item and hold it until the block takes it. Valid stays
    // high between back-to-back items; it only drops on an idle cycle.
    task automatic send_item(op_t op, logic [PORT_W-1:0] p, logic ok);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.port      <= p;
        req_ch.healthy   <= ok;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predictor.note_request(op, p, ok);
    endtask

    // Hold the request side idle until every owed result has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (predictor.awaited.size() != 0)
            @(posedge clk);
    endtask

    // Random items drawn mostly from a small port pool, so that adds hit ports
    // already listed, removes hit listed ports, and the list fills up and drains.
    // The add/remove balance drifts every 60 items.
    task automatic run_random(int count);
        op_t               op;
        logic [PORT_W-1:0] p;
        logic              ok;
        int                add_pct;
        add_pct = 85;
        for (int k = 0; k < count; k++)
        begin
            if (k % 60 == 0)
            begin
                case ($urandom_range(2))
                    0:       add_pct = 85;
                    1:       add_pct = 50;
                    default: add_pct = 20;
                endcase
            end
            op = ($urandom_range(99) < 40) ? OP_SELECT : OP_HEALTH;
            ok = ($urandom_range(99) < add_pct);
            p  = port_pool[$urandom_range(POOL_N - 1)];
            // Most failed reports name a port that is actually listed.
            if (op == OP_HEALTH && !ok && predictor.listed != 0 && $urandom_range(3) != 0)
                p = predictor.roster[$urandom_range(predictor.listed - 1)];
            if ($urandom_range(19) == 0)
                p = PORT_W'($urandom);
            send_item(op, p, ok);
        end
    endtask

    // Result side: check each accepted result, then pick ready for the next cycle.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                predictor.check_result(rsp_ch.chosen_port, rsp_ch.status);
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: count cycles in which neither channel moves an item.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_SELECT;
        req_ch.port      = '0;
        req_ch.healthy   = 1'b0;
        rst_n            = 1'b0;
        send_idle_pct    = 6;
        recv_idle_pct    = 57;

        // Pool holds both extreme port values; the rest are random.
        port_pool[0] = '0;
        port_pool[1] = '1;
        for (int i = 2; i < POOL_N; i++)
            port_pool[i] = PORT_W'($urandom);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, port zero as a real port, duplicates, rotation
        // with wrap, removal from the middle and tail, removal of an absent port.
        send_item(OP_SELECT, 16'hBEEF, 1'b1);   // empty list: none available
        send_item(OP_HEALTH, 16'h0000, 1'b0);   // remove from empty list
        send_item(OP_HEALTH, 16'h0000, 1'b1);   // port zero is an ordinary port
        send_item(OP_HEALTH, 16'hFFFF, 1'b1);
        send_item(OP_HEALTH, 16'h0000, 1'b1);   // already listed
        send_item(OP_HEALTH, 16'h1234, 1'b1);
        send_item(OP_HEALTH, 16'hA5A5, 1'b1);
        send_item(OP_SELECT, 16'h0000, 1'b0);
        send_item(OP_SELECT, 16'hFFFF, 1'b1);
        send_item(OP_SELECT, 16'h5A5A, 1'b0);
        send_item(OP_SELECT, 16'h0001, 1'b1);
        send_item(OP_SELECT, 16'h8000, 1'b0);   // index wraps to zero
        send_item(OP_HEALTH, 16'hFFFF, 1'b0);   // remove from the middle
        send_item(OP_HEALTH, 16'hFFFF, 1'b0);   // now absent
        send_item(OP_SELECT, 16'h0000, 1'b0);
        send_item(OP_SELECT, 16'h0000, 1'b0);
        send_item(OP_HEALTH, 16'hA5A5, 1'b0);   // remove tail; index now past count
        send_item(OP_SELECT, 16'h0000, 1'b0);   // wraps after removal
        send_item(OP_HEALTH, 16'h1234, 1'b0);
        send_item(OP_HEALTH, 16'h0000, 1'b0);   // list empty again
        send_item(OP_SELECT, 16'hFFFF, 1'b1);
        send_item(OP_HEALTH, 16'h5A5A, 1'b1);
        send_item(OP_SELECT, 16'h0000, 1'b0);
        send_item(OP_SELECT, 16'h0000, 1'b0);
        wait_drained();

        // Slow receiver, then slow sender, then full rate.
        run_random(380);
        wait_drained();
        send_idle_pct = 57;
        recv_idle_pct = 6;
        run_random(400);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(400);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (predictor.errors == 0 && predictor.awaited.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// File: health_aware_round_robin_selector_unit.f
rtl/core/hars_pkg.sv
rtl/core/hars_req_if.sv
rtl/core/hars_rsp_if.sv
rtl/core/health_aware_round_robin_selector_unit.sv
sim/health_aware_round_robin_selector_unit_tb.sv
